// File: rtl/core/alpha_bounding_box_unit_defines.svh
// Assertion macros for the alpha bounding box unit.
`ifndef ALPHA_BOUNDING_BOX_UNIT_DEFINES_SVH
`define ALPHA_BOUNDING_BOX_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is held.
`define ABB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ABB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/abb_pkg.sv
// Shared types and constants of the alpha bounding box unit.
package abb_pkg;

  localparam int ABB_MAX_DIM = 4096;
  localparam int CFG_W       = 13;
  localparam int BOX_DIM_W   = 14;
  localparam int PIXEL_W     = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_W-1:0] RST_FRAME_DIM = 13'd4096;
  localparam logic [7:0]       ALPHA_MASK    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RGBA_MODE    = 3'd2,
    REG_PRIOR_COL    = 3'd3,
    REG_PRIOR_ROW    = 3'd4,
    REG_PRIOR_WIDTH  = 3'd5,
    REG_PRIOR_HEIGHT = 3'd6
  } abb_reg_t;

  // Covered extent of one frame: smallest and one-past-last column and row.
  typedef struct packed {
    logic [CFG_W-1:0] min_col;
    logic [CFG_W-1:0] min_row;
    logic [CFG_W-1:0] end_col;
    logic [CFG_W-1:0] end_row;
  } abb_extent_t;

endpackage

// File: rtl/core/alpha_bounding_box_unit.sv
// Alpha bounding box unit: top level with configuration, result stages and checks.
// Takes one pixel per clock in raster order and never stalls the source while the result
// path flows. At the last pixel of a frame the covered extent is latched in the frame
// extent stage, merged combinationally with the prior rectangle and registered in the
// result register that drives the result port. The input stalls only when a finished
// frame result is still held because the result port is stalled. Registers are
// written through the cfg_ port, which is always ready; write them only while idle.
`include "alpha_bounding_box_unit_defines.svh"

module alpha_bounding_box_unit import abb_pkg::*; #(
  parameter int MAX_DIM = ABB_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIXEL_W-1:0]   in_pixel_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found_any,
  output logic [CFG_W-1:0]     out_box_col,
  output logic [CFG_W-1:0]     out_box_row,
  output logic [BOX_DIM_W-1:0] out_box_width,
  output logic [BOX_DIM_W-1:0] out_box_height,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic             rgba_mode_r;
  logic [CFG_W-1:0] prior_col_r, prior_row_r, prior_width_r, prior_height_r;

  logic             pix_acc, frame_end;
  abb_extent_t      extent_nxt;
  logic             ext_valid_r;
  abb_extent_t      ext_r;
  logic             out_ready, ext_ready;

  logic                 found, prior_ok;
  logic [CFG_W-1:0]     left, top;
  logic [BOX_DIM_W-1:0] right, bottom, prior_right, prior_bottom;
  logic                 res_found;
  logic [CFG_W-1:0]     res_col, res_row;
  logic [BOX_DIM_W-1:0] res_width, res_height;

  logic                 out_valid_r, out_found_any_r;
  logic [CFG_W-1:0]     out_box_col_r, out_box_row_r;
  logic [BOX_DIM_W-1:0] out_box_width_r, out_box_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_DIM;
      frame_height_r <= RST_FRAME_DIM;
      rgba_mode_r    <= 1'b0;
      prior_col_r    <= '0;
      prior_row_r    <= '0;
      prior_width_r  <= '0;
      prior_height_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (abb_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_RGBA_MODE:    rgba_mode_r    <= cfg_data[0];
        REG_PRIOR_COL:    prior_col_r    <= cfg_data;
        REG_PRIOR_ROW:    prior_row_r    <= cfg_data;
        REG_PRIOR_WIDTH:  prior_width_r  <= cfg_data;
        REG_PRIOR_HEIGHT: prior_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign ext_ready = !ext_valid_r || out_ready;
  assign in_stall  = !ext_ready;
  assign pix_acc   = in_valid && !in_stall;

  abb_tracker #(
    .MAX_DIM(MAX_DIM)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_acc      (pix_acc),
    .pixel_word   (in_pixel_word),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .rgba_mode    (rgba_mode_r),
    .frame_end    (frame_end),
    .extent_nxt   (extent_nxt)
  );

  // Frame extent stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_valid_r <= 1'b0;
    end else if (ext_ready) begin
      ext_valid_r <= pix_acc && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (ext_ready && pix_acc && frame_end) begin
      ext_r <= extent_nxt;
    end
  end

  // Merge with prior rectangle
  always_comb begin
    found        = (ext_r.end_col > ext_r.min_col) && (ext_r.end_row > ext_r.min_row);
    prior_ok     = (prior_width_r != '0) && (prior_height_r != '0);
    prior_right  = BOX_DIM_W'(prior_col_r) + BOX_DIM_W'(prior_width_r);
    prior_bottom = BOX_DIM_W'(prior_row_r) + BOX_DIM_W'(prior_height_r);
    left   = (prior_ok && prior_col_r < ext_r.min_col) ? prior_col_r : ext_r.min_col;
    top    = (prior_ok && prior_row_r < ext_r.min_row) ? prior_row_r : ext_r.min_row;
    right  = (prior_ok && prior_right > BOX_DIM_W'(ext_r.end_col)) ?
             prior_right : BOX_DIM_W'(ext_r.end_col);
    bottom = (prior_ok && prior_bottom > BOX_DIM_W'(ext_r.end_row)) ?
             prior_bottom : BOX_DIM_W'(ext_r.end_row);
    res_found = found;
    if (found) begin
      res_col    = left;
      res_row    = top;
      res_width  = right - BOX_DIM_W'(left);
      res_height = bottom - BOX_DIM_W'(top);
    end else begin
      res_col    = prior_col_r;
      res_row    = prior_row_r;
      res_width  = BOX_DIM_W'(prior_width_r);
      res_height = BOX_DIM_W'(prior_height_r);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= ext_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && ext_valid_r) begin
      out_found_any_r  <= res_found;
      out_box_col_r    <= res_col;
      out_box_row_r    <= res_row;
      out_box_width_r  <= res_width;
      out_box_height_r <= res_height;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found_any  = out_found_any_r;
  assign out_box_col    = out_box_col_r;
  assign out_box_row    = out_box_row_r;
  assign out_box_width  = out_box_width_r;
  assign out_box_height = out_box_height_r;

  `ABB_ASSERT(a_found_box_nonempty, clk, rst_n, out_valid && out_found_any |-> out_box_width != '0 && out_box_height != '0, "found transaction with empty box")
  `ABB_ASSERT(a_backpressure_stalls_input, clk, rst_n, ext_valid_r && out_valid && out_stall |-> in_stall, "input not stalled while result path is full")
  `ABB_ASSERT(a_frame_end_captured, clk, rst_n, pix_acc && frame_end |=> ext_valid_r, "frame end not captured")
  `ABB_ASSERT_ALWAYS(a_cfg_always_ready, clk, cfg_ready, "configuration port not ready")

endmodule

// File: rtl/core/abb_tracker.sv
// Raster position counters and covered-extent tracking for one frame.
module abb_tracker import abb_pkg::*; #(
  parameter int MAX_DIM = ABB_MAX_DIM
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pix_acc,
  input  logic [PIXEL_W-1:0] pixel_word,
  input  logic [CFG_W-1:0]  frame_width,
  input  logic [CFG_W-1:0]  frame_height,
  input  logic              rgba_mode,
  output logic              frame_end,
  output abb_extent_t       extent_nxt
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int KW = (CW > CFG_W) ? CW : CFG_W;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = CFG_W'(MAX_DIM);
    end
    return r;
  endfunction

  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    row_r, row_nxt;
  abb_extent_t      ext_r;
  logic [CFG_W-1:0] eff_w, eff_h, col13, row13;
  logic [7:0]       alpha;
  logic             covered, last_col, last_row;

  always_comb begin
    eff_w    = eff_dim(frame_width);
    eff_h    = eff_dim(frame_height);
    alpha    = (rgba_mode ? pixel_word[31:24] : pixel_word[7:0]) & ALPHA_MASK;
    covered  = (alpha != 8'd0);
    last_col = KW'(col_r) >= KW'(eff_w - CFG_W'(1));
    last_row = KW'(row_r) >= KW'(eff_h - CFG_W'(1));
    frame_end = last_col && last_row;
    col13    = CFG_W'(col_r);
    row13    = CFG_W'(row_r);

    extent_nxt = ext_r;
    if (covered) begin
      if (col13 < ext_r.min_col) extent_nxt.min_col = col13;
      if (row13 < ext_r.min_row) extent_nxt.min_row = row13;
      if (col13 + CFG_W'(1) > ext_r.end_col) extent_nxt.end_col = col13 + CFG_W'(1);
      extent_nxt.end_row = row13 + CFG_W'(1);
    end

    col_nxt = last_col ? '0 : col_r + CW'(1);
    row_nxt = row_r;
    if (last_col) begin
      row_nxt = last_row ? '0 : row_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      ext_r.min_col <= eff_dim(RST_FRAME_DIM);
      ext_r.min_row <= eff_dim(RST_FRAME_DIM);
      ext_r.end_col <= '0;
      ext_r.end_row <= '0;
    end else if (pix_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (frame_end) begin
        ext_r.min_col <= eff_w;
        ext_r.min_row <= eff_h;
        ext_r.end_col <= '0;
        ext_r.end_row <= '0;
      end else begin
        ext_r <= extent_nxt;
      end
    end
  end

endmodule

// File: bench/tb_alpha_bounding_box_unit.sv
// Self-checking bench for the alpha bounding box unit: frame stimulus and box prediction.
module tb_alpha_bounding_box_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import abb_pkg::*;

  localparam int RANDOM_ITEMS   = 835;
  localparam int SETTLE_CYCLES  = 6;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct packed {
    logic                 found;
    logic [CFG_W-1:0]     col;
    logic [CFG_W-1:0]     row;
    logic [BOX_DIM_W-1:0] width;
    logic [BOX_DIM_W-1:0] height;
  } bbox_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIXEL_W-1:0]   in_pixel_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found_any;
  logic [CFG_W-1:0]     out_box_col;
  logic [CFG_W-1:0]     out_box_row;
  logic [BOX_DIM_W-1:0] out_box_width;
  logic [BOX_DIM_W-1:0] out_box_height;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predicted copy of the registers and the frame tracker
  logic [CFG_W-1:0] frame_w_cfg, frame_h_cfg;
  logic             rgba_cfg;
  logic [CFG_W-1:0] prior_col_cfg, prior_row_cfg, prior_w_cfg, prior_h_cfg;
  logic [11:0]      col_pos, row_pos;
  logic [CFG_W-1:0] min_col, min_row, end_col, end_row;
  bbox_t            pending_boxes[$];

  int  mismatches = 0;
  int  pixels_taken = 0;
  int  boxes_seen = 0;
  int  reg_writes = 0;
  int  quiet_cycles = 0;
  int  hold_ticket = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;
  bit  cur_rgba = 1'b0;

  alpha_bounding_box_unit dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return CFG_W'(1);
    if (v > ABB_MAX_DIM) return CFG_W'(ABB_MAX_DIM);
    return v;
  endfunction

  task automatic reload_extent();
    min_col = clamp_dim(frame_w_cfg);
    min_row = clamp_dim(frame_h_cfg);
    end_col = '0;
    end_row = '0;
  endtask

  function automatic bbox_t frame_box();
    logic [BOX_DIM_W-1:0] left, top, right, bottom;
    bbox_t box;
    if (end_col > min_col && end_row > min_row) begin
      left = BOX_DIM_W'(min_col);
      top = BOX_DIM_W'(min_row);
      right = BOX_DIM_W'(end_col);
      bottom = BOX_DIM_W'(end_row);
      if (prior_w_cfg != 0 && prior_h_cfg != 0) begin
        if (BOX_DIM_W'(prior_col_cfg) < left) left = BOX_DIM_W'(prior_col_cfg);
        if (BOX_DIM_W'(prior_row_cfg) < top) top = BOX_DIM_W'(prior_row_cfg);
        if (BOX_DIM_W'(prior_col_cfg) + BOX_DIM_W'(prior_w_cfg) > right)
          right = BOX_DIM_W'(prior_col_cfg) + BOX_DIM_W'(prior_w_cfg);
        if (BOX_DIM_W'(prior_row_cfg) + BOX_DIM_W'(prior_h_cfg) > bottom)
          bottom = BOX_DIM_W'(prior_row_cfg) + BOX_DIM_W'(prior_h_cfg);
      end
      box.found = 1'b1;
      box.col = left[CFG_W-1:0];
      box.row = top[CFG_W-1:0];
      box.width = right - left;
      box.height = bottom - top;
    end else begin
      box.found = 1'b0;
      box.col = prior_col_cfg;
      box.row = prior_row_cfg;
      box.width = BOX_DIM_W'(prior_w_cfg);
      box.height = BOX_DIM_W'(prior_h_cfg);
    end
    return box;
  endfunction

  task automatic track_pixel(input logic [PIXEL_W-1:0] word);
    logic [CFG_W-1:0] w, h;
    logic [7:0]       alpha;
    logic             last_col, last_row;
    w = clamp_dim(frame_w_cfg);
    h = clamp_dim(frame_h_cfg);
    alpha = rgba_cfg ? word[31:24] : word[7:0];
    last_col = CFG_W'(col_pos) >= w - CFG_W'(1);
    last_row = CFG_W'(row_pos) >= h - CFG_W'(1);
    if (alpha != 0) begin
      if (CFG_W'(col_pos) < min_col) min_col = CFG_W'(col_pos);
      if (CFG_W'(row_pos) < min_row) min_row = CFG_W'(row_pos);
      if (CFG_W'(col_pos) + 13'd1 > end_col) end_col = CFG_W'(col_pos) + 13'd1;
      end_row = CFG_W'(row_pos) + 13'd1;
    end
    if (!last_col) begin
      col_pos = col_pos + 1'b1;
    end else begin
      col_pos = '0;
      if (!last_row) begin
        row_pos = row_pos + 1'b1;
      end else begin
        row_pos = '0;
        pending_boxes.insert(pending_boxes.size(), frame_box());
        reload_extent();
      end
    end
  endtask

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // Monitor: register writes, pixel transactions and result checks, plus the watchdog
  always @(posedge clk) begin
    bbox_t want;
    bit    progress;
    if (!rst_n) begin
      frame_w_cfg = RST_FRAME_DIM;
      frame_h_cfg = RST_FRAME_DIM;
      rgba_cfg = 1'b0;
      prior_col_cfg = '0;
      prior_row_cfg = '0;
      prior_w_cfg = '0;
      prior_h_cfg = '0;
      col_pos = '0;
      row_pos = '0;
      reload_extent();
      pending_boxes.delete();
      quiet_cycles = 0;
    end else begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (abb_reg_t'(cfg_index))
          REG_FRAME_WIDTH:  frame_w_cfg = cfg_data;
          REG_FRAME_HEIGHT: frame_h_cfg = cfg_data;
          REG_RGBA_MODE:    rgba_cfg = cfg_data[0];
          REG_PRIOR_COL:    prior_col_cfg = cfg_data;
          REG_PRIOR_ROW:    prior_row_cfg = cfg_data;
          REG_PRIOR_WIDTH:  prior_w_cfg = cfg_data;
          REG_PRIOR_HEIGHT: prior_h_cfg = cfg_data;
          default: ;
        endcase
        reg_writes++;
        progress = 1'b1;
      end
      if (in_valid && !in_stall) begin
        track_pixel(in_pixel_word);
        pixels_taken++;
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        boxes_seen++;
        progress = 1'b1;
        if (pending_boxes.size() == 0) begin
          note_mismatch($sformatf("result with none pending: found %0d col %0d row %0d",
                                  out_found_any, out_box_col, out_box_row));
        end else begin
          want = pending_boxes.pop_front();
          if (out_found_any !== want.found)
            note_mismatch($sformatf("found_any expected %0d got %0d", want.found, out_found_any));
          if (out_box_col !== want.col)
            note_mismatch($sformatf("box_col expected %0d got %0d", want.col, out_box_col));
          if (out_box_row !== want.row)
            note_mismatch($sformatf("box_row expected %0d got %0d", want.row, out_box_row));
          if (out_box_width !== want.width)
            note_mismatch($sformatf("box_width expected %0d got %0d", want.width, out_box_width));
          if (out_box_height !== want.height)
            note_mismatch($sformatf("box_height expected %0d got %0d", want.height,
                                    out_box_height));
        end
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  function automatic logic [PIXEL_W-1:0] make_pixel(input bit covered, input bit rgba);
    logic [PIXEL_W-1:0] word;
    logic [7:0]         alpha;
    word = $urandom;
    alpha = covered ? 8'($urandom_range(1, 255)) : 8'h00;
    if (rgba) word[31:24] = alpha;
    else word[7:0] = alpha;
    return word;
  endfunction

  function automatic logic [CFG_W-1:0] pick_extent(input int lo);
    return CFG_W'(($urandom_range(4) == 0) ? $urandom_range(lo, 4096) : $urandom_range(lo, 12));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_pixel(input logic [PIXEL_W-1:0] word);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 12) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input abb_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] w, h, mode, pc, pr, pw, ph);
    drain_results();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_write(REG_RGBA_MODE, mode);
    cfg_write(REG_PRIOR_COL, pc);
    cfg_write(REG_PRIOR_ROW, pr);
    cfg_write(REG_PRIOR_WIDTH, pw);
    cfg_write(REG_PRIOR_HEIGHT, ph);
    cfg_valid <= 1'b0;
    cur_rgba = mode[0];
  endtask

  // Zero size reads as one pixel; alpha taken from the low byte only
  task automatic test_tiny_frames();
    load_setting(0, 0, 0, 0, 0, 0, 0);
    send_pixel(32'h0000_00FF);
    send_pixel(32'hFFFF_FF00);
    send_pixel(32'h0000_0001);
  endtask

  task automatic test_rgba_alpha();
    load_setting(1, 1, 1, 0, 0, 0, 0);
    send_pixel(32'hFF00_0000);
    send_pixel(32'h00FF_FFFF);
  endtask

  // Union with the largest prior, then an empty prior, then nothing covered
  task automatic test_prior_merge();
    load_setting(2, 2, 0, 4096, 4096, 4096, 4096);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0080);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0000);
    load_setting(2, 2, 0, 5, 7, 0, 4096);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0010);
    send_pixel(32'h0000_0000);
    repeat (4) send_pixel(32'hFFFF_FF00);
  endtask

  // Frame shrunk while the column counter sits past the new last column and the row counter on the new last row
  task automatic test_resize_mid_frame();
    load_setting(4, 3, 0, 0, 0, 0, 0);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0020);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_007F);
    load_setting(1, 2, 0, 0, 0, 0, 0);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0040);
    send_pixel(32'h0000_0000);
  endtask

  task automatic test_streaming();
    calm <= 1'b1;
    load_setting(3, 2, 0, 1, 1, 2, 2);
    repeat (150) send_pixel(make_pixel($urandom_range(99) < 30, cur_rgba));
    drain_results();
    calm <= 1'b0;
  endtask

  // One-pixel frames while the result side holds off, so the input must stall
  task automatic test_backpressure();
    load_setting(1, 1, 0, 3, 4, 2, 2);
    hold_ticket <= hold_ticket + 1;
    repeat (40) send_pixel(make_pixel($urandom_range(1) == 1, cur_rgba));
  endtask

  // Oversized width and height, each frame closed early by shrinking it
  task automatic test_size_limits();
    int hot;
    load_setting(8191, 1, 1, 0, 0, 0, 0);
    hot = $urandom_range(0, 255);
    for (int n = 0; n < 256; n++)
      send_pixel(make_pixel(n == hot || n == 255 || $urandom_range(99) == 0, cur_rgba));
    load_setting(1, 1, 1, 0, 0, 0, 0);
    send_pixel(make_pixel(1'b0, cur_rgba));
    load_setting(3, 8191, 0, 10, 0, 4096, 1);
    hot = $urandom_range(0, 239);
    for (int n = 0; n < 240; n++)
      send_pixel(make_pixel(n == hot || $urandom_range(99) == 0, cur_rgba));
    load_setting(3, 1, 0, 10, 0, 4096, 1);
    repeat (3) send_pixel(make_pixel(1'b0, cur_rgba));
  endtask

  task automatic test_random_frames();
    logic [CFG_W-1:0] w, h, mode, pc, pr, pw, ph;
    int sent, frames, area, cut, density;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = CFG_W'(($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6));
      h = CFG_W'(($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5));
      mode = CFG_W'($urandom);
      pc = pick_extent(0);
      pr = pick_extent(0);
      pw = pick_extent(1);
      ph = pick_extent(1);
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(1) == 1) pw = '0;
        else ph = '0;
      end
      load_setting(w, h, mode, pc, pr, pw, ph);
      frames = $urandom_range(1, 4);
      area = clamp_dim(w) * clamp_dim(h);
      cut = ($urandom_range(5) == 0) ? $urandom_range(1, frames * area) : frames * area;
      if (cut > RANDOM_ITEMS - sent) cut = RANDOM_ITEMS - sent;
      density = 0;
      for (int n = 0; n < cut; n++) begin
        if (n % area == 0) begin
          case ($urandom_range(3))
            0: density = 0;
            1: density = 8;
            2: density = 40;
            default: density = 100;
          endcase
        end
        send_pixel(make_pixel($urandom_range(99) < density, cur_rgba));
      end
      sent += cut;
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_tiny_frames();
    test_rgba_alpha();
    test_prior_merge();
    test_resize_mid_frame();
    test_streaming();
    test_backpressure();
    test_size_limits();
    test_random_frames();
    drain_results();
    $display("Covered %0d pixel transactions, %0d frame boxes, %0d register writes:",
             pixels_taken, boxes_seen, reg_writes);
    $display("  L8 and RGBA alpha, frame sizes 0 to 8191, empty and full priors, mid-frame resize.");
    if (mismatches == 0 && pending_boxes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d boxes never produced", mismatches, pending_boxes.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
